### sv/wtpl_pkg.sv
`timescale 1ns / 1ps

package wtpl_pkg;

   // configuration register indexes
   typedef enum logic [7:0] {
      REG_PROP_GAIN    = 8'd0,
      REG_INTEG_GAIN   = 8'd1,
      REG_WIRE_GAUGE   = 8'd2,
      REG_SPOOL_DIAM   = 8'd3
   } csr_index_type;

   localparam int unsigned SAMPLE_PORT_W = 12;
   localparam int unsigned DUTY_W        = 14;
   localparam int unsigned TARGET_W      = 13;
   localparam int unsigned GAIN_W        = 16;
   localparam int unsigned GAUGE_W       = 8;
   localparam int unsigned DIAM_W        = 11;

   localparam logic [DUTY_W-1:0]   DUTY_MAX       = 14'd10000;
   localparam logic [TARGET_W-1:0] TARGET_CAP     = 13'd6000;
   localparam logic [TARGET_W-1:0] TARGET_DEFAULT = 13'd4800;
   localparam logic [GAUGE_W-1:0]  GAUGE_LOW      = 8'd25;
   localparam logic [GAUGE_W-1:0]  GAUGE_HIGH     = 8'd40;

   // register reset values
   localparam logic [GAUGE_W-1:0]  GAUGE_RESET = 8'd40;
   localparam logic [DIAM_W-1:0]   DIAM_RESET  = 11'd10;

   // base current setpoint for gauges 25 through 40, others use the default
   function automatic logic [TARGET_W-1:0] base_target(input logic [GAUGE_W-1:0] awg);
      logic [3:0]          idx;
      logic [TARGET_W-1:0] val;
      idx = 4'(awg - GAUGE_LOW);
      case (idx)
         4'd0:    val = 13'd3500;
         4'd1:    val = 13'd3200;
         4'd2:    val = 13'd2900;
         4'd3:    val = 13'd2800;
         4'd4:    val = 13'd2700;
         4'd5:    val = 13'd2600;
         4'd6:    val = 13'd2500;
         4'd7:    val = 13'd2400;
         4'd8:    val = 13'd2300;
         4'd9:    val = 13'd2200;
         4'd10:   val = 13'd2100;
         4'd11:   val = 13'd2000;
         4'd12:   val = 13'd1800;
         4'd13:   val = 13'd1700;
         4'd14:   val = 13'd1600;
         default: val = 13'd1500;
      endcase
      if (awg < GAUGE_LOW || awg > GAUGE_HIGH) begin
         val = TARGET_DEFAULT;
      end
      return val;
   endfunction

endpackage

### sv/wtpl_filter.sv
`timescale 1ns / 1ps

module wtpl_filter #(
   parameter int unsigned FILT_W = 12
) (
   input  logic [FILT_W-1:0] sample,
   input  logic [FILT_W-1:0] filt,
   output logic [FILT_W-1:0] filt_next
);

   logic signed [FILT_W:0] diff;
   logic signed [FILT_W:0] diff_adj;
   logic signed [FILT_W:0] step;

   // move a quarter of the way toward the sample, quotient toward zero
   always_comb begin
      diff      = $signed({1'b0, sample}) - $signed({1'b0, filt});
      diff_adj  = diff + $signed({{(FILT_W-1){1'b0}}, diff[FILT_W], diff[FILT_W]});
      step      = diff_adj >>> 2;
      filt_next = filt + step[FILT_W-1:0];
   end

endmodule

### sv/wtpl_setpoint.sv
`timescale 1ns / 1ps

module wtpl_setpoint (
   input  logic [wtpl_pkg::GAUGE_W-1:0]  wire_gauge,
   input  logic [wtpl_pkg::DIAM_W-1:0]   spool_diam,
   output logic [wtpl_pkg::TARGET_W-1:0] target
);

   localparam int unsigned RAW_W = wtpl_pkg::TARGET_W + 1;

   logic [RAW_W-1:0] diam_x3;
   logic [RAW_W-1:0] raw;

   // table base plus three per diameter unit, capped
   always_comb begin
      diam_x3 = RAW_W'({spool_diam, 1'b0}) + RAW_W'(spool_diam);
      raw     = RAW_W'(wtpl_pkg::base_target(wire_gauge)) + diam_x3;
      if (raw > RAW_W'(wtpl_pkg::TARGET_CAP)) begin
         target = wtpl_pkg::TARGET_CAP;
      end else begin
         target = raw[wtpl_pkg::TARGET_W-1:0];
      end
   end

endmodule

### sv/wtpl_pi_core.sv
`timescale 1ns / 1ps

module wtpl_pi_core #(
   parameter int unsigned FILT_W = 12
) (
   input  logic [FILT_W-1:0]                   pv,
   input  logic [FILT_W-1:0]                   prev_pv,
   input  logic [wtpl_pkg::TARGET_W-1:0]       target,
   input  logic [wtpl_pkg::DUTY_W-1:0]         duty_acc,
   input  logic signed [wtpl_pkg::GAIN_W-1:0]  prop_gain,
   input  logic signed [wtpl_pkg::GAIN_W-1:0]  integ_gain,
   input  logic                                run,
   output logic [wtpl_pkg::DUTY_W-1:0]         duty
);

   localparam int unsigned DIFF_W = FILT_W + 1;
   localparam int unsigned ERR_W  =
      ((FILT_W > wtpl_pkg::TARGET_W) ? FILT_W : wtpl_pkg::TARGET_W) + 2;
   localparam int unsigned PP_W   = DIFF_W + wtpl_pkg::GAIN_W;
   localparam int unsigned PI_W   = ERR_W + wtpl_pkg::GAIN_W;
   localparam int unsigned SUM_W  = PI_W + 2;

   logic signed [DIFF_W-1:0] diff;
   logic signed [ERR_W-1:0]  err;
   logic signed [PP_W-1:0]   prod_p;
   logic signed [PI_W-1:0]   prod_i;
   logic signed [PP_W-1:0]   half_p;
   logic signed [PI_W-1:0]   half_i;
   logic signed [SUM_W-1:0]  sum;

   // measurement change and setpoint error
   always_comb begin
      diff = $signed({1'b0, prev_pv}) - $signed({1'b0, pv});
      err  = $signed(ERR_W'(target)) - $signed(ERR_W'(pv));
   end

   // gain products, halved toward zero
   always_comb begin
      prod_p = diff * prop_gain;
      prod_i = err * integ_gain;
      half_p = (prod_p + $signed({{(PP_W-1){1'b0}}, prod_p[PP_W-1]})) >>> 1;
      half_i = (prod_i + $signed({{(PI_W-1){1'b0}}, prod_i[PI_W-1]})) >>> 1;
   end

   // accumulate and clamp
   always_comb begin
      sum = $signed(SUM_W'(duty_acc)) + SUM_W'(half_p) + SUM_W'(half_i);
      if (!run || sum[SUM_W-1]) begin
         duty = '0;
      end else if (sum > $signed(SUM_W'(wtpl_pkg::DUTY_MAX))) begin
         duty = wtpl_pkg::DUTY_MAX;
      end else begin
         duty = sum[wtpl_pkg::DUTY_W-1:0];
      end
   end

endmodule

### sv/winder_torque_pi_loop.sv
`timescale 1ns / 1ps

// Winding-motor current loop: each item is one raw ADC current sample and a run
// flag; the block filters the sample (a quarter step toward it), latches the
// current setpoint from wire gauge and spool diameter while running, and takes
// one incremental PI step, returning the clamped duty (0..10000, zero when not
// running), the setpoint used and the filtered current. One item enters per
// cycle while rsp_stall is low: an item waits in the input register, and the
// whole filter, setpoint and PI step then run combinationally into the result
// register and the loop state, so an accepted item passes through the input
// register and then the result register. While a result waits, the input
// register still takes one more item; req_stall rises only when both
// registers hold an item. Registers may be written only while no item is in
// flight.
module winder_torque_pi_loop #(
   parameter int unsigned ADC_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   // sample channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [11:0] req_current_sample,
   input  logic        req_running,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [13:0] rsp_motor_duty,
   output logic [12:0] rsp_current_target,
   output logic [11:0] rsp_filtered_current,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int unsigned FILT_W =
      (ADC_BITS < wtpl_pkg::SAMPLE_PORT_W) ? ADC_BITS : wtpl_pkg::SAMPLE_PORT_W;

   // configuration registers
   logic signed [wtpl_pkg::GAIN_W-1:0]  prop_gain_ff;
   logic signed [wtpl_pkg::GAIN_W-1:0]  integ_gain_ff;
   logic [wtpl_pkg::GAUGE_W-1:0]        wire_gauge_ff;
   logic [wtpl_pkg::DIAM_W-1:0]         spool_diam_ff;

   // loop state
   logic [FILT_W-1:0]                   filter_ff;
   logic [FILT_W-1:0]                   prev_measure_ff;
   logic [wtpl_pkg::DUTY_W-1:0]         duty_acc_ff;
   logic [wtpl_pkg::TARGET_W-1:0]       held_target_ff;

   // input and result registers
   logic                                in_valid_ff;
   logic                                in_valid_in;
   logic [FILT_W-1:0]                   sample_ff;
   logic                                running_ff;
   logic                                out_valid_ff;
   logic                                out_valid_in;
   logic [13:0]                         duty_out_ff;
   logic [12:0]                         target_out_ff;
   logic [11:0]                         filt_out_ff;

   logic                                accept_in;
   logic                                advance;
   logic [FILT_W-1:0]                   filter_in;
   logic [wtpl_pkg::TARGET_W-1:0]       new_target;
   logic [wtpl_pkg::TARGET_W-1:0]       held_target_in;
   logic [wtpl_pkg::DUTY_W-1:0]         duty_in;

   // handshake control
   always_comb begin
      advance      = in_valid_ff && (!out_valid_ff || !rsp_stall);
      req_stall    = in_valid_ff && !advance;
      accept_in    = req_valid && !req_stall;
      in_valid_in  = accept_in || req_stall;
      out_valid_in = advance || (out_valid_ff && rsp_stall);
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_motor_duty       = duty_out_ff;
   assign rsp_current_target   = target_out_ff;
   assign rsp_filtered_current = filt_out_ff;
   assign csr_ready            = 1'b1;

   // register writes, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= '0;
         integ_gain_ff <= '0;
         wire_gauge_ff <= wtpl_pkg::GAUGE_RESET;
         spool_diam_ff <= wtpl_pkg::DIAM_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            wtpl_pkg::REG_PROP_GAIN:  prop_gain_ff  <= $signed(csr_wdata);
            wtpl_pkg::REG_INTEG_GAIN: integ_gain_ff <= $signed(csr_wdata);
            wtpl_pkg::REG_WIRE_GAUGE: wire_gauge_ff <= csr_wdata[wtpl_pkg::GAUGE_W-1:0];
            wtpl_pkg::REG_SPOOL_DIAM: spool_diam_ff <= csr_wdata[wtpl_pkg::DIAM_W-1:0];
            default: ;
         endcase
      end
   end

   wtpl_filter #(
      .FILT_W (FILT_W)
   ) u_filter (
      .sample    (sample_ff),
      .filt      (filter_ff),
      .filt_next (filter_in)
   );

   wtpl_setpoint u_setpoint (
      .wire_gauge (wire_gauge_ff),
      .spool_diam (spool_diam_ff),
      .target     (new_target)
   );

   // setpoint is relatched only while running
   assign held_target_in = running_ff ? new_target : held_target_ff;

   wtpl_pi_core #(
      .FILT_W (FILT_W)
   ) u_pi_core (
      .pv         (filter_in),
      .prev_pv    (prev_measure_ff),
      .target     (held_target_in),
      .duty_acc   (duty_acc_ff),
      .prop_gain  (prop_gain_ff),
      .integ_gain (integ_gain_ff),
      .run        (running_ff),
      .duty       (duty_in)
   );

   // control flags and loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         filter_ff       <= '0;
         prev_measure_ff <= '0;
         duty_acc_ff     <= '0;
         held_target_ff  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            filter_ff       <= filter_in;
            prev_measure_ff <= filter_in;
            duty_acc_ff     <= duty_in;
            held_target_ff  <= held_target_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept_in) begin
         sample_ff  <= req_current_sample[FILT_W-1:0];
         running_ff <= req_running;
      end
      if (advance) begin
         duty_out_ff   <= duty_in;
         target_out_ff <= held_target_in;
         filt_out_ff   <= 12'(filter_in);
      end
   end

   // duty never leaves its range
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_motor_duty <= wtpl_pkg::DUTY_MAX)
      else $error("duty above limit");

   // setpoint never exceeds its cap
   a_target_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_current_target <= wtpl_pkg::TARGET_CAP)
      else $error("setpoint above cap");

   // a step taken while stopped leaves zero duty behind
   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      (advance && !running_ff) |=> duty_acc_ff == '0)
      else $error("duty not zero after stop");

   // every step taken shows up as a result
   a_step_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("step lost");

   // stored result matches the loop state it came from
   a_out_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_motor_duty == duty_acc_ff)
      else $error("result and state disagree");

endmodule
